@@ src/button_gesture_detector_core_macros.svh @@
// Assertion macros for the button gesture detector.
// Included by button_gesture_detector_core, which checks its own logic; no other dependencies.
`ifndef BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that prop holds at every rising edge of clk outside reset.
`define BGD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("bgd assertion failed");
// Check that cond never holds at a rising edge of clk outside reset.
`define BGD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("bgd forbidden condition seen");
`else
`define BGD_ASSERT(lbl, clk, rst_n, prop)
`define BGD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ src/bgd_pkg.sv @@
// Shared types, constants and register codes of the button gesture detector.
// No dependencies.
package bgd_pkg;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 4;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_BITS-1:0] HOLD_RST       = 16'd1500;
  localparam logic [CFG_BITS-1:0] SOS_RST        = 16'd8000;
  localparam logic [CFG_BITS-1:0] SOS_REPEAT_RST = 16'd2000;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_HOLD       = 2'd1,
    REG_SOS        = 2'd2,
    REG_SOS_REPEAT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_HOLD   = 2'd2,
    GEST_SOS    = 2'd3
  } gesture_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] hold_ms;
    logic [CFG_BITS-1:0] sos_ms;
    logic [CFG_BITS-1:0] sos_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic                 key_pressed;
    logic                 authorized;
  } item_t;

  typedef struct packed {
    logic                  raw_level;
    logic                  stable_level;
    logic                  short_press_pending;
    logic [TIME_BITS-1:0]  press_stamp;
    logic [TIME_BITS-1:0]  release_stamp;
    logic [COUNT_BITS-1:0] single_count;
    logic [COUNT_BITS-1:0] hold_count;
    logic [COUNT_BITS-1:0] sos_count;
  } state_t;

  typedef struct packed {
    logic                  gesture_valid;
    gesture_e              gesture_code;
    logic                  press_wake;
    logic                  press_clock_start;
    logic [COUNT_BITS-1:0] single_total;
    logic [COUNT_BITS-1:0] hold_total;
    logic [COUNT_BITS-1:0] sos_total;
  } result_t;

endpackage

@@ src/bgd_in_if.sv @@
// Input channel of the button gesture detector: one key sample per request.
// Depends on bgd_pkg for field widths.
interface bgd_in_if;
  logic                          valid;
  logic                          ready;
  logic [bgd_pkg::TIME_BITS-1:0] now_ms;
  logic                          key_pressed;
  logic                          authorized;

  modport source (output valid, now_ms, key_pressed, authorized, input ready);
  modport sink   (input valid, now_ms, key_pressed, authorized, output ready);
endinterface

@@ src/bgd_out_if.sv @@
// Result channel of the button gesture detector: one result per request.
// Depends on bgd_pkg for field widths.
interface bgd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           gesture_valid;
  logic [1:0]                     gesture_code;
  logic                           press_wake;
  logic                           press_clock_start;
  logic [bgd_pkg::COUNT_BITS-1:0] single_total;
  logic [bgd_pkg::COUNT_BITS-1:0] hold_total;
  logic [bgd_pkg::COUNT_BITS-1:0] sos_total;

  modport source (output valid, gesture_valid, gesture_code, press_wake, press_clock_start,
                  single_total, hold_total, sos_total, input ready);
  modport sink   (input valid, gesture_valid, gesture_code, press_wake, press_clock_start,
                  single_total, hold_total, sos_total, output ready);
endinterface

@@ src/bgd_cfg_regs.sv @@
// APB-style configuration registers: debounce, hold, SOS and SOS repeat times.
// Depends on bgd_pkg for register codes, reset values and the cfg_t struct.
module bgd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bgd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [bgd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bgd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output bgd_pkg::cfg_t                     cfg_o
);

  bgd_pkg::cfg_t     cfg_q, cfg_d;
  bgd_pkg::cfg_reg_e reg_sel;
  logic              wr_en;
  logic [bgd_pkg::CFG_BITS-1:0] wdata;
  logic [bgd_pkg::CFG_BITS-1:0] rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = bgd_pkg::cfg_reg_e'(paddr[3:2]);
  assign wdata   = pwdata[bgd_pkg::CFG_BITS-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        bgd_pkg::REG_DEBOUNCE:   cfg_d.debounce_ms   = wdata;
        bgd_pkg::REG_HOLD:       cfg_d.hold_ms       = wdata;
        bgd_pkg::REG_SOS:        cfg_d.sos_ms        = wdata;
        bgd_pkg::REG_SOS_REPEAT: cfg_d.sos_repeat_ms = wdata;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bgd_pkg::REG_DEBOUNCE:   rdata = cfg_q.debounce_ms;
      bgd_pkg::REG_HOLD:       rdata = cfg_q.hold_ms;
      bgd_pkg::REG_SOS:        rdata = cfg_q.sos_ms;
      bgd_pkg::REG_SOS_REPEAT: rdata = cfg_q.sos_repeat_ms;
      default:                 rdata = '0;
    endcase
  end

  assign prdata = {{(bgd_pkg::APB_DATA_BITS - bgd_pkg::CFG_BITS){1'b0}}, rdata};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= bgd_pkg::DEBOUNCE_RST;
      cfg_q.hold_ms       <= bgd_pkg::HOLD_RST;
      cfg_q.sos_ms        <= bgd_pkg::SOS_RST;
      cfg_q.sos_repeat_ms <= bgd_pkg::SOS_REPEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/bgd_classifier.sv @@
// Edge stamping and gesture classification for one key sample.
// Pure combinational next-state and result logic; depends on bgd_pkg.
module bgd_classifier (
  input  bgd_pkg::cfg_t   cfg_i,
  input  bgd_pkg::item_t  item_i,
  input  bgd_pkg::state_t state_i,
  output bgd_pkg::state_t state_o,
  output bgd_pkg::result_t result_o
);

  localparam int unsigned TB = bgd_pkg::TIME_BITS;
  localparam int unsigned CB = bgd_pkg::CFG_BITS;

  logic [TB-1:0] press_stamp;
  logic [TB-1:0] release_stamp;
  logic          raw_level;
  logic [TB-1:0] dt_press;
  logic [TB-1:0] dt_release;
  logic [TB-1:0] dt_span;
  logic [TB-1:0] debounce_w;
  logic [TB-1:0] hold_w;
  logic [TB-1:0] sos_w;
  logic [TB-1:0] repeat_w;
  logic          level_change;
  bgd_pkg::gesture_e gesture;

  assign debounce_w = {{(TB - CB){1'b0}}, cfg_i.debounce_ms};
  assign hold_w     = {{(TB - CB){1'b0}}, cfg_i.hold_ms};
  assign sos_w      = {{(TB - CB){1'b0}}, cfg_i.sos_ms};
  assign repeat_w   = {{(TB - CB){1'b0}}, cfg_i.sos_repeat_ms};

  // Stamp the raw level change first; the classifier sees the new stamps.
  assign level_change  = item_i.key_pressed != state_i.raw_level;
  assign raw_level     = item_i.key_pressed;
  assign press_stamp   = (level_change && item_i.key_pressed) ? item_i.now_ms
                                                              : state_i.press_stamp;
  assign release_stamp = (level_change && !item_i.key_pressed) ? item_i.now_ms
                                                               : state_i.release_stamp;

  assign dt_press   = item_i.now_ms - press_stamp;
  assign dt_release = item_i.now_ms - release_stamp;
  assign dt_span    = release_stamp - press_stamp;

  always_comb begin
    state_o               = state_i;
    state_o.raw_level     = raw_level;
    state_o.press_stamp   = press_stamp;
    state_o.release_stamp = release_stamp;
    gesture               = bgd_pkg::GEST_NONE;

    if (state_i.stable_level && raw_level) begin
      // Stable press: SOS repeats by pushing the press stamp forward.
      if (item_i.authorized && dt_press >= sos_w) begin
        state_o.press_stamp = press_stamp + repeat_w;
        state_o.sos_count   = state_i.sos_count + 1'b1;
        gesture             = bgd_pkg::GEST_SOS;
      end
    end else if (raw_level) begin
      if (dt_press >= debounce_w) begin
        if (dt_press >= hold_w) begin
          state_o.stable_level        = 1'b1;
          state_o.short_press_pending = 1'b0;
          state_o.hold_count          = state_i.hold_count + 1'b1;
          gesture                     = bgd_pkg::GEST_HOLD;
        end else begin
          state_o.short_press_pending = 1'b1;
        end
      end
    end else begin
      if (dt_release >= debounce_w) begin
        if (state_i.short_press_pending && dt_span < hold_w) begin
          state_o.short_press_pending = 1'b0;
          state_o.single_count        = state_i.single_count + 1'b1;
          gesture                     = bgd_pkg::GEST_SINGLE;
        end else begin
          state_o.stable_level        = 1'b0;
          state_o.short_press_pending = 1'b0;
        end
      end
    end
  end

  always_comb begin
    result_o.gesture_valid     = gesture != bgd_pkg::GEST_NONE;
    result_o.gesture_code      = gesture;
    result_o.press_wake        = level_change && item_i.key_pressed && item_i.authorized;
    result_o.press_clock_start = level_change && item_i.key_pressed && !item_i.authorized;
    result_o.single_total      = state_o.single_count;
    result_o.hold_total        = state_o.hold_count;
    result_o.sos_total         = state_o.sos_count;
  end

endmodule

@@ src/button_gesture_detector_core.sv @@
// Top level of the button gesture detector: input register, classifier, result register.
// Depends on bgd_pkg, bgd_in_if, bgd_out_if, bgd_cfg_regs, bgd_classifier and the macros.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  in_ch    | in        | valid / ready      | now_ms, key_pressed, authorized
//  out_ch   | out       | valid / ready      | gesture_valid, gesture_code, press_wake,
//           |           |                    | press_clock_start, single/hold/sos_total
//  apb      | in        | psel/penable/pready| debounce_ms, hold_ms, sos_ms, sos_repeat_ms
//
// One request per cycle sustained while the result side does not stall; a taken request passes
// through the input register, then the classifier into the result register.
// Reset clears the key state, the stamps, the counters and both stage valids, and loads
// the register defaults.
// A stalled result holds the result register; the input register still takes one more
// request, after which in_ch.ready drops until the result is taken.
`include "button_gesture_detector_core_macros.svh"

module button_gesture_detector_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bgd_in_if.sink                            in_ch,
  bgd_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bgd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [bgd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bgd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  bgd_pkg::cfg_t    cfg;
  bgd_pkg::item_t   item_q;
  bgd_pkg::state_t  state_q, state_d;
  bgd_pkg::result_t result_q, result_d;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             in_take;
  logic             advance;

  bgd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgd_classifier u_classifier (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Advance the held request when the result register is free or being emptied.
  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.now_ms      <= in_ch.now_ms;
      item_q.key_pressed <= in_ch.key_pressed;
      item_q.authorized  <= in_ch.authorized;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.gesture_valid     = result_q.gesture_valid;
  assign out_ch.gesture_code      = result_q.gesture_code;
  assign out_ch.press_wake        = result_q.press_wake;
  assign out_ch.press_clock_start = result_q.press_clock_start;
  assign out_ch.single_total      = result_q.single_total;
  assign out_ch.hold_total        = result_q.hold_total;
  assign out_ch.sos_total         = result_q.sos_total;

  `BGD_ASSERT(a_hold_state_when_idle, clk_i, rst_ni,
              !advance |=> $stable(state_q))
  `BGD_ASSERT(a_advance_fills_result, clk_i, rst_ni, advance |=> out_valid_q)
  `BGD_ASSERT(a_block_input_on_full_stall, clk_i, rst_ni,
              (in_valid_q && out_valid_q && !out_ch.ready) |-> !in_ch.ready)
  `BGD_ASSERT_NEVER(a_wake_and_clock_start, clk_i, rst_ni,
                    out_valid_q && result_q.press_wake && result_q.press_clock_start)

endmodule

@@ bench/tb.sv @@
// Self-checking bench for button_gesture_detector_core: directed key sequences, then
// randomized press/release patterns under several register settings, with idle gaps.
// Depends on bgd_pkg, bgd_in_if, bgd_out_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgd_pkg::*;

  localparam int PHASES    = 8;
  localparam int PER_PHASE = 212;
  localparam int CALM_REQS = 40;

  typedef struct packed {
    logic [TIME_BITS-1:0]  now;
    logic                  key;
    logic                  auth;
    logic                  typed;
    gesture_e              code;
    logic                  wake;
    logic                  cstart;
    logic [COUNT_BITS-1:0] n_single;
    logic [COUNT_BITS-1:0] n_hold;
    logic [COUNT_BITS-1:0] n_sos;
  } key_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  bgd_in_if  in_ch ();
  bgd_out_if out_ch ();

  button_gesture_detector_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Key samples at the reset setting: click, hold, SOS and repeat, time wrap, bounce.
  key_row_t key_rows [23] = '{
    '{32'd0,        1'b0, 1'b0, 1'b1, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd100,      1'b1, 1'b0, 1'b1, GEST_NONE,   1'b0, 1'b1, 16'd0, 16'd0, 16'd0},
    '{32'd200,      1'b1, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd220,      1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd300,      1'b0, 1'b0, 1'b1, GEST_SINGLE, 1'b0, 1'b0, 16'd1, 16'd0, 16'd0},
    '{32'd400,      1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd1000,     1'b1, 1'b1, 1'b1, GEST_NONE,   1'b1, 1'b0, 16'd1, 16'd0, 16'd0},
    '{32'd2600,     1'b1, 1'b1, 1'b1, GEST_HOLD,   1'b0, 1'b0, 16'd1, 16'd1, 16'd0},
    '{32'd9000,     1'b1, 1'b1, 1'b1, GEST_SOS,    1'b0, 1'b0, 16'd1, 16'd1, 16'd1},
    '{32'd10000,    1'b1, 1'b1, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd11000,    1'b1, 1'b1, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd30000,    1'b1, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd30010,    1'b0, 1'b1, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'd30100,    1'b0, 1'b1, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'hFFFFFFF0, 1'b1, 1'b1, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00000040, 1'b1, 1'b1, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00000050, 1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00001000, 1'b1, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00001001, 1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00001002, 1'b1, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00001003, 1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{32'h00002000, 1'b0, 1'b0, 1'b0, GEST_NONE,   1'b0, 1'b0, 16'd0, 16'd0, 16'd0}
  };

  state_t  key_st;
  cfg_t    key_cfg;
  result_t gesture_q [$];

  int errors;
  int n_reqs;
  int n_single;
  int n_hold;
  int n_sos;
  int n_settings;
  bit calm;

  // Random key pattern generator state.
  logic [TIME_BITS-1:0] gen_ms;
  int unsigned          seg_left;
  int unsigned          seg_span;
  logic                 seg_level;
  logic                 seg_auth;

  function automatic result_t predict_gesture(item_t it);
    result_t              r;
    gesture_e             g;
    logic [TIME_BITS-1:0] dt;
    r = '0;
    g = GEST_NONE;
    if (it.key_pressed != key_st.raw_level) begin
      key_st.raw_level = it.key_pressed;
      if (it.key_pressed) begin
        key_st.press_stamp = it.now_ms;
        if (it.authorized) r.press_wake = 1'b1;
        else r.press_clock_start = 1'b1;
      end else begin
        key_st.release_stamp = it.now_ms;
      end
    end
    if (key_st.raw_level && key_st.stable_level) begin
      dt = it.now_ms - key_st.press_stamp;
      if (it.authorized && dt >= TIME_BITS'(key_cfg.sos_ms)) begin
        key_st.press_stamp = key_st.press_stamp + TIME_BITS'(key_cfg.sos_repeat_ms);
        key_st.sos_count   = key_st.sos_count + 1'b1;
        g = GEST_SOS;
      end
    end else if (key_st.raw_level) begin
      dt = it.now_ms - key_st.press_stamp;
      if (dt >= TIME_BITS'(key_cfg.debounce_ms)) begin
        if (dt >= TIME_BITS'(key_cfg.hold_ms)) begin
          key_st.stable_level        = 1'b1;
          key_st.short_press_pending = 1'b0;
          key_st.hold_count          = key_st.hold_count + 1'b1;
          g = GEST_HOLD;
        end else begin
          key_st.short_press_pending = 1'b1;
        end
      end
    end else begin
      dt = it.now_ms - key_st.release_stamp;
      if (dt >= TIME_BITS'(key_cfg.debounce_ms)) begin
        dt = key_st.release_stamp - key_st.press_stamp;
        if (key_st.short_press_pending && dt < TIME_BITS'(key_cfg.hold_ms)) begin
          key_st.short_press_pending = 1'b0;
          key_st.single_count        = key_st.single_count + 1'b1;
          g = GEST_SINGLE;
        end else begin
          key_st.stable_level        = 1'b0;
          key_st.short_press_pending = 1'b0;
        end
      end
    end
    r.gesture_valid = (g != GEST_NONE);
    r.gesture_code  = g;
    r.single_total  = key_st.single_count;
    r.hold_total    = key_st.hold_count;
    r.sos_total     = key_st.sos_count;
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_req(item_t it, bit typed, result_t typed_res);
    int unsigned gap;
    result_t     pred;
    gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.now_ms      <= it.now_ms;
    in_ch.key_pressed <= it.key_pressed;
    in_ch.authorized  <= it.authorized;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pred = predict_gesture(it);
    gesture_q.push_back(typed ? typed_res : pred);
    n_reqs++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DATA_BITS-CFG_BITS){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DEBOUNCE:   key_cfg.debounce_ms   = value;
      REG_HOLD:       key_cfg.hold_ms       = value;
      REG_SOS:        key_cfg.sos_ms        = value;
      REG_SOS_REPEAT: key_cfg.sos_repeat_ms = value;
      default: ;
    endcase
  endtask

  task automatic program_cfg(cfg_t c);
    write_reg(REG_DEBOUNCE, c.debounce_ms);
    write_reg(REG_HOLD, c.hold_ms);
    write_reg(REG_SOS, c.sos_ms);
    write_reg(REG_SOS_REPEAT, c.sos_repeat_ms);
    n_settings++;
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Press/release segments sized against the thresholds, with some noise mixed in.
  function automatic item_t next_key_sample();
    item_t       it;
    int unsigned deb;
    int unsigned hold;
    int unsigned sos;
    int unsigned rep;
    int unsigned tgt;
    deb  = 32'(key_cfg.debounce_ms);
    hold = 32'(key_cfg.hold_ms);
    sos  = 32'(key_cfg.sos_ms);
    rep  = 32'(key_cfg.sos_repeat_ms);
    if ($urandom_range(0, 99) < 8) begin
      gen_ms         = $urandom;
      it.now_ms      = gen_ms;
      it.key_pressed = 1'($urandom_range(0, 1));
      it.authorized  = 1'($urandom_range(0, 1));
      return it;
    end
    if (seg_left == 0) begin
      if ($urandom_range(0, 9) != 0) seg_level = !seg_level;
      seg_auth = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1:       tgt = $urandom_range(0, deb);
        2, 3, 4, 5: tgt = $urandom_range(deb, hold);
        6, 7:       tgt = $urandom_range(hold, sos);
        default:    tgt = $urandom_range(sos, sos + 4 * rep);
      endcase
      seg_left = $urandom_range(1, 6);
      seg_span = tgt / seg_left;
    end
    seg_left--;
    if ($urandom_range(0, 19) == 0) seg_auth = !seg_auth;
    gen_ms         = gen_ms + $urandom_range(seg_span / 2, seg_span + seg_span / 2 + 1);
    it.now_ms      = gen_ms;
    it.key_pressed = seg_level;
    it.authorized  = seg_auth;
    return it;
  endfunction

  // Result side: random stalls, none started during calm stretches.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) < 2) begin
        stall_left = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (gesture_q.size() == 0) begin
        $error("result taken with no request outstanding");
        errors++;
      end else begin
        want = gesture_q.pop_front();
        check_field("gesture_valid", 32'(want.gesture_valid), 32'(out_ch.gesture_valid));
        check_field("gesture_code", 32'(want.gesture_code), 32'(out_ch.gesture_code));
        check_field("press_wake", 32'(want.press_wake), 32'(out_ch.press_wake));
        check_field("press_clock_start", 32'(want.press_clock_start),
                    32'(out_ch.press_clock_start));
        check_field("single_total", 32'(want.single_total), 32'(out_ch.single_total));
        check_field("hold_total", 32'(want.hold_total), 32'(out_ch.hold_total));
        check_field("sos_total", 32'(want.sos_total), 32'(out_ch.sos_total));
        case (want.gesture_code)
          GEST_SINGLE: n_single++;
          GEST_HOLD:   n_hold++;
          GEST_SOS:    n_sos++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    item_t   it;
    result_t res;
    cfg_t    phase_cfg;
    int      waited;
    errors     = 0;
    n_reqs     = 0;
    n_single   = 0;
    n_hold     = 0;
    n_sos      = 0;
    n_settings = 1;
    calm       = 1'b0;
    gen_ms     = $urandom;
    seg_left   = 0;
    seg_span   = 0;
    seg_level  = 1'b0;
    seg_auth   = 1'b1;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.now_ms      <= '0;
    in_ch.key_pressed <= 1'b0;
    in_ch.authorized  <= 1'b0;
    key_st  = '0;
    key_cfg = '{DEBOUNCE_RST, HOLD_RST, SOS_RST, SOS_REPEAT_RST};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (key_rows[i]) begin
      it.now_ms      = key_rows[i].now;
      it.key_pressed = key_rows[i].key;
      it.authorized  = key_rows[i].auth;
      res.gesture_valid     = (key_rows[i].code != GEST_NONE);
      res.gesture_code      = key_rows[i].code;
      res.press_wake        = key_rows[i].wake;
      res.press_clock_start = key_rows[i].cstart;
      res.single_total      = key_rows[i].n_single;
      res.hold_total        = key_rows[i].n_hold;
      res.sos_total         = key_rows[i].n_sos;
      send_req(it, key_rows[i].typed, res);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        case (p)
          1: phase_cfg = '{16'd5, 16'd20, 16'd60, 16'd10};
          2: phase_cfg = '{16'd0, 16'd0, 16'd0, 16'd0};
          3: phase_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          4: phase_cfg = '{16'd0, 16'd1, 16'd1, 16'd1};
          5: phase_cfg = '{16'($urandom_range(0, 40)), 16'($urandom_range(1, 300)),
                           16'($urandom_range(1, 900)), 16'($urandom_range(1, 200))};
          6: phase_cfg = '{16'($urandom_range(0, 500)), 16'($urandom_range(1, 500)),
                           16'($urandom_range(1, 500)), 16'($urandom_range(1, 500))};
          default: phase_cfg = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        drain();
        program_cfg(phase_cfg);
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        calm = (n < CALM_REQS);
        it = next_key_sample();
        send_req(it, 1'b0, '0);
      end
      calm = 1'b0;
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    while (gesture_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    if (gesture_q.size() != 0) begin
      $error("%0d results never arrived", gesture_q.size());
      errors++;
    end
    repeat (8) @(posedge clk_i);
    $display("%0d key samples over %0d register settings", n_reqs, n_settings);
    $display("gestures checked: %0d single, %0d hold, %0d SOS", n_single, n_hold, n_sos);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
